### sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// shared types and constants of the matrix multiply engine
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  // fixed field widths
  localparam int IDX_W     = 3;   // row and column index fields
  localparam int DIM_W     = 4;   // dimension registers
  localparam int ACT_W     = 2;   // action field
  localparam int WORD_W    = 32;  // element and result words
  localparam int ACC_W     = 64;  // accumulator
  localparam int FRAC_BITS = 16;  // q16.16

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  // register indexes on the apb port
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;   // first term of an element: clear the accumulator
    logic             last_k;  // final term of an element: emit it
    logic             last;    // final element of the result matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

### sv/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// q16.16 general matrix multiply: loads a and b into two stores, then
// streams out every element of a*b in row-major order
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   ------------------------   ------------------------------------
//  input     start & !busy              in_action, in_elem_row, in_elem_col,
//                                       in_element_value
//  result    out_valid, one cycle       out_product_value, out_row, out_col,
//                                       out_last
//  config    psel & penable & pwrite    paddr, pwdata, prdata, pready (=1)
//
//  a write word (a or b element) leaves busy low, so one write can be taken
//  every cycle while no compute is running
//  a compute word issues one multiply-accumulate per cycle, a rate set by
//  the single read port of each store, over every (r, c, k) step, then
//  drains the pipeline; busy is high for all of it
//  rst_n is synchronous, active low; store contents are not cleared
//  the receiver cannot stall: each result word is shown for one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_core
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 32
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [IDX_W-1:0]  in_elem_row,
  input  wire logic [IDX_W-1:0]  in_elem_col,
  input  wire logic [WORD_W-1:0] in_element_value,
  // result channel
  output logic                   out_valid,
  output logic [WORD_W-1:0]      out_product_value,
  output logic [IDX_W-1:0]       out_row,
  output logic [IDX_W-1:0]       out_col,
  output logic                   out_last,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0]      prdata,
  output logic                   pready
);

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DIM_LIMIT = (MAX_DIM < 8) ? MAX_DIM : 8;

  // dimension register -> last index, with 0 acting as 1 and big values clamped
  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(DIM_LIMIT);
    if (d == '0) begin
      return '0;
    end else if (d > lim) begin
      return IDX_W'(lim - DIM_W'(1));
    end else begin
      return IDX_W'(d - DIM_W'(1));
    end
  endfunction

  // store entry row*MAX_DIM+col
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  endfunction

  // configuration registers
  logic [DIM_W-1:0] rows_a_r;
  logic [DIM_W-1:0] inner_dim_r;
  logic [DIM_W-1:0] cols_b_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // sequencer
  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] nr_m1, nc_m1, nk_m1;
  logic             r_last, c_last, k_last;
  logic             issue_en;
  logic             accept;
  logic             go_compute;
  tag_t             tag_issue;
  tag_t             tag1_r;
  logic             pipe_active;

  // stores
  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a_r;
  logic [ELEM_WIDTH-1:0] rd_b_r;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_a_addr;
  logic [ADDR_W-1:0]     rd_b_addr;
  logic                  wr_in_range;
  logic                  wr_a;
  logic                  wr_b;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROWS_A:    rows_a_r    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[DIM_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS_A:    prdata = WORD_W'(rows_a_r);
      REG_INNER_DIM: prdata = WORD_W'(inner_dim_r);
      REG_COLS_B:    prdata = WORD_W'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // input words: element writes go straight to the stores
  // --------------------------------------------------------------------------
  assign accept      = start && !busy;
  // writes past the store edge are dropped
  assign wr_in_range = (int'(in_elem_row) < MAX_DIM) && (int'(in_elem_col) < MAX_DIM);
  assign wr_a        = accept && wr_in_range && (in_action == ACT_WRITE_A);
  assign wr_b        = accept && wr_in_range && (in_action == ACT_WRITE_B);
  assign go_compute  = accept && (in_action == ACT_COMPUTE);
  assign wr_addr     = addr_of(in_elem_row, in_elem_col);

  // --------------------------------------------------------------------------
  // sequencer: walks r, c, k and issues one a/b read pair per cycle
  // --------------------------------------------------------------------------
  assign nr_m1  = last_idx(rows_a_r);
  assign nc_m1  = last_idx(cols_b_r);
  assign nk_m1  = last_idx(inner_dim_r);
  assign r_last = (r_r == nr_m1);
  assign c_last = (c_r == nc_m1);
  assign k_last = (k_r == nk_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go_compute) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (r_last && c_last && k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last element to leave the pipeline
        if (!tag1_r.valid && !pipe_active) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        issue_en = 1'b0;
      end
      ST_ISSUE: begin
        busy     = 1'b1;
        issue_en = 1'b1;
      end
      ST_DRAIN: begin
        busy     = 1'b1;
        issue_en = 1'b0;
      end
      default: begin
        busy     = 1'b0;
        issue_en = 1'b0;
      end
    endcase
  end

  // index counters, k fastest, then c, then r
  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    if (go_compute) begin
      r_nxt = '0;
      c_nxt = '0;
      k_nxt = '0;
    end else if (issue_en) begin
      if (!k_last) begin
        k_nxt = k_r + IDX_W'(1);
      end else begin
        k_nxt = '0;
        if (!c_last) begin
          c_nxt = c_r + IDX_W'(1);
        end else begin
          c_nxt = '0;
          r_nxt = r_r + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    tag_issue.valid  = issue_en;
    tag_issue.first  = (k_r == '0);
    tag_issue.last_k = k_last;
    tag_issue.last   = r_last && c_last;
    tag_issue.row    = r_r;
    tag_issue.col    = c_r;
  end

  assign rd_a_addr = addr_of(r_r, k_r);
  assign rd_b_addr = addr_of(k_r, c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
      tag1_r  <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      // tag is registered alongside the registered store read data, so the two line up
      tag1_r  <= tag_issue;
    end
  end

  // --------------------------------------------------------------------------
  // stores, one write and one registered read port each; writes and compute
  // reads never overlap since busy blocks writes while computing
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_element_value[ELEM_WIDTH-1:0];
    end
    rd_a_r <= mem_a[rd_a_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_element_value[ELEM_WIDTH-1:0];
    end
    rd_b_r <= mem_b[rd_b_addr];
  end

  // --------------------------------------------------------------------------
  // multiply-accumulate pipeline and result register
  // --------------------------------------------------------------------------
  mme_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_data    (rd_a_r),
    .b_data    (rd_b_r),
    .tag_in    (tag1_r),
    .res_valid (out_valid),
    .res_value (out_product_value),
    .res_row   (out_row),
    .res_col   (out_col),
    .res_last  (out_last),
    .active    (pipe_active)
  );

endmodule

`default_nettype wire

### sv/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// multiply, accumulate and saturate pipeline for one result element at a time
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac
  import mme_pkg::*;
#(
  parameter int ELEM_WIDTH = 32
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [ELEM_WIDTH-1:0] a_data,
  input  wire logic [ELEM_WIDTH-1:0] b_data,
  input  wire tag_t                  tag_in,
  output logic                       res_valid,
  output logic [WORD_W-1:0]          res_value,
  output logic [IDX_W-1:0]           res_row,
  output logic [IDX_W-1:0]           res_col,
  output logic                       res_last,
  output logic                       active
);

  localparam logic signed [ACC_W-1:0] SAT_HI = (64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SAT_LO = -(64'sd1 <<< (ELEM_WIDTH - 1));

  logic signed [ELEM_WIDTH-1:0]   a_s;
  logic signed [ELEM_WIDTH-1:0]   b_s;
  logic signed [2*ELEM_WIDTH-1:0] prod_full;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        prod_nxt;
  logic signed [ACC_W-1:0]        prod_r;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        sat;
  tag_t                           tag2_r;
  tag_t                           tag3_r;
  logic                           res_valid_r;
  logic [WORD_W-1:0]              res_value_r;
  logic [IDX_W-1:0]               res_row_r;
  logic [IDX_W-1:0]               res_col_r;
  logic                           res_last_r;

  // exact product, floored to q16.16
  assign a_s       = a_data;
  assign b_s       = b_data;
  assign prod_full = a_s * b_s;
  assign prod_ext  = ACC_W'(prod_full);
  assign prod_nxt  = prod_ext >>> FRAC_BITS;

  assign acc_nxt = (tag2_r.first ? '0 : acc_r) + prod_r;

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat = SAT_HI;
    end else if (acc_r < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      tag3_r      <= '0;
      acc_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      tag2_r      <= tag_in;
      tag3_r      <= tag2_r;
      if (tag2_r.valid) begin
        acc_r <= acc_nxt;
      end
      res_valid_r <= tag3_r.valid && tag3_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (tag3_r.valid && tag3_r.last_k) begin
      res_value_r <= sat[WORD_W-1:0];
      res_row_r   <= tag3_r.row;
      res_col_r   <= tag3_r.col;
      res_last_r  <= tag3_r.last;
    end
  end

  assign res_valid = res_valid_r;
  assign res_value = res_value_r;
  assign res_row   = res_row_r;
  assign res_col   = res_col_r;
  assign res_last  = res_last_r;
  assign active    = tag2_r.valid || tag3_r.valid;

endmodule

`default_nettype wire

### sv/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// port-level checks of the matrix multiply engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker
  import mme_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [ACT_W-1:0] in_action,
  input wire logic             out_valid,
  input wire logic             out_last
);

  // results only appear during a compute
  a_out_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside a compute");

  // a compute word starts a busy period
  a_compute_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_COMPUTE)) |=> busy)
    else $error("compute word did not raise busy");

  // element writes never block the next word
  a_write_free : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_WRITE_A || in_action == ACT_WRITE_B))
      |=> !busy)
    else $error("element write raised busy");

  // after the final element nothing follows at once
  a_last_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result word right after the final element");

  // the engine stays busy until the final element is out
  a_busy_until_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> busy)
    else $error("busy dropped before the final element");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_last  (out_last)
);

`default_nettype wire
